// ===== rtl/core/sfsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted free-slot allocator package
// Shared constants, the controller command code and the datapath status.
// ----------------------------------------------------------------------------
package sfsa_pkg;

    localparam int SLOT_W        = 9;
    localparam int CNT_W         = 8;
    localparam int FUNC_W        = 2;
    localparam int HIGHEST_W     = 8;
    localparam int DEF_MAX_SLOTS = 256;

    localparam logic [SLOT_W-1:0]    NO_SLOT     = 9'h1FF;
    localparam logic [CNT_W-1:0]     CNT_MAX     = 8'hFF;
    localparam logic [HIGHEST_W-1:0] HIGHEST_RST = 8'hFF;

    localparam logic [FUNC_W-1:0] FUNC_OCCUPY  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MOVE    = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_REL_RD,
        OP_DEC,
        OP_WALK_RD,
        OP_WALK_ADV,
        OP_LINK_A,
        OP_LINK_B,
        OP_FILL,
        OP_FILL_END,
        OP_NEW_RD,
        OP_LNK_RD,
        OP_UNLINK,
        OP_INC,
        OP_RES_RD,
        OP_OUT
    } t_op;

    typedef struct packed {
        logic rel_go;
        logic occ_ok;
        logic new_ge_hw;
        logic occ_zero;
        logic occ_one;
        logic walk_more;
        logic fill_more;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/core/sfsa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted free-slot allocator controller
// Sequences release, list walk, linking, fill, unlink and result steps.
// ----------------------------------------------------------------------------
module sfsa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sfsa_pkg::t_status i_status,
    output sfsa_pkg::t_op    o_op
);
    import sfsa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_REL, S_REL_CHK, S_WALK, S_WALK_W, S_LINK_B, S_OCC, S_FILL,
        S_NEW_CHK, S_UNLINK, S_INC, S_RES_RD, S_OUT
    } t_state;

    t_state r_state, n_state;
    t_op    n_op;

    always_comb begin
        n_state = r_state;
        n_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = OP_LATCH;
                    n_state = S_REL;
                end
            end
            S_REL: begin
                if (i_status.rel_go) begin
                    n_op    = OP_REL_RD;
                    n_state = S_REL_CHK;
                end else begin
                    n_state = S_OCC;
                end
            end
            S_REL_CHK: begin
                if (i_status.occ_zero) begin
                    n_state = S_OCC;
                end else begin
                    n_op    = OP_DEC;
                    n_state = i_status.occ_one ? S_WALK : S_OCC;
                end
            end
            S_WALK: begin
                if (i_status.walk_more) begin
                    n_op    = OP_WALK_RD;
                    n_state = S_WALK_W;
                end else begin
                    n_op    = OP_LINK_A;
                    n_state = S_LINK_B;
                end
            end
            S_WALK_W: begin
                n_op    = OP_WALK_ADV;
                n_state = S_WALK;
            end
            S_LINK_B: begin
                n_op    = OP_LINK_B;
                n_state = S_OCC;
            end
            S_OCC: begin
                if (!i_status.occ_ok) begin
                    n_state = S_RES_RD;
                end else if (i_status.new_ge_hw) begin
                    n_state = S_FILL;
                end else begin
                    n_op    = OP_NEW_RD;
                    n_state = S_NEW_CHK;
                end
            end
            S_FILL: begin
                if (i_status.fill_more) begin
                    n_op = OP_FILL;
                end else begin
                    n_op    = OP_FILL_END;
                    n_state = S_RES_RD;
                end
            end
            S_NEW_CHK: begin
                if (i_status.occ_zero) begin
                    n_op    = OP_LNK_RD;
                    n_state = S_UNLINK;
                end else begin
                    n_op    = OP_INC;
                    n_state = S_RES_RD;
                end
            end
            S_UNLINK: begin
                n_op    = OP_UNLINK;
                n_state = S_INC;
            end
            S_INC: begin
                n_op    = OP_INC;
                n_state = S_RES_RD;
            end
            S_RES_RD: begin
                n_op    = OP_RES_RD;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    n_op    = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_op       = n_op;

endmodule

// ===== rtl/core/sfsa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted free-slot allocator datapath
// Occupancy and link tables, list head and tail, high-water mark and result.
// ----------------------------------------------------------------------------
module sfsa_dp #(
    parameter int MAX_SLOTS = sfsa_pkg::DEF_MAX_SLOTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sfsa_pkg::t_op                    i_op,
    output sfsa_pkg::t_status                o_status,
    input  logic [sfsa_pkg::FUNC_W-1:0]      i_func,
    input  logic signed [sfsa_pkg::SLOT_W-1:0] i_new_slot,
    input  logic signed [sfsa_pkg::SLOT_W-1:0] i_old_slot,
    input  logic                             i_cfg_we,
    input  logic [sfsa_pkg::HIGHEST_W-1:0]   i_cfg_wdata,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic signed [sfsa_pkg::SLOT_W-1:0] o_free_head,
    output logic [sfsa_pkg::SLOT_W-1:0]      o_next_unused,
    output logic [sfsa_pkg::CNT_W-1:0]       o_slot_users,
    output logic                             o_table_full,
    output logic                             o_ignored
);
    import sfsa_pkg::*;

    localparam int AW = $clog2(MAX_SLOTS);

    logic [CNT_W-1:0]  occ_mem  [MAX_SLOTS];
    logic [SLOT_W-1:0] prev_mem [MAX_SLOTS];
    logic [SLOT_W-1:0] next_mem [MAX_SLOTS];

    logic              occ_we, occ_re, prev_we, prev_re, next_we, next_re;
    logic [AW-1:0]     occ_waddr, occ_raddr, prev_waddr, prev_raddr;
    logic [AW-1:0]     next_waddr, next_raddr;
    logic [CNT_W-1:0]  occ_wdata;
    logic [SLOT_W-1:0] prev_wdata, next_wdata;
    logic [CNT_W-1:0]  r_occ_q;
    logic [SLOT_W-1:0] r_prev_q, r_next_q;

    logic [HIGHEST_W-1:0] r_highest, n_highest;
    logic [SLOT_W-1:0] r_ns, n_ns, r_os, n_os;
    logic              r_rel_ok, n_rel_ok, r_occ_ok, n_occ_ok;
    logic              r_ns_use, n_ns_use, r_ign, n_ign, r_res_hit, n_res_hit;
    logic [SLOT_W-1:0] r_hw, n_hw, r_head, n_head, r_tail, n_tail;
    logic [SLOT_W-1:0] r_before, n_before, r_after, n_after;
    logic              r_out_valid, n_out_valid;
    logic [SLOT_W-1:0] r_o_head, n_o_head, r_o_hw, n_o_hw;
    logic [CNT_W-1:0]  r_o_users, n_o_users;
    logic              r_o_full, n_o_full, r_o_ign, n_o_ign;

    logic              do_rel, do_occ, os_use;
    logic [SLOT_W-1:0] ns9, os9;

    function automatic logic is_usable(input logic [SLOT_W-1:0] s,
                                       input logic [HIGHEST_W-1:0] hi);
        return !s[SLOT_W-1] && (s[HIGHEST_W-1:0] <= hi)
               && (32'(s[HIGHEST_W-1:0]) < MAX_SLOTS);
    endfunction

    function automatic logic [AW-1:0] idx(input logic [SLOT_W-1:0] s);
        return AW'(s[HIGHEST_W-1:0]);
    endfunction

    assign ns9 = {1'b0, r_ns[HIGHEST_W-1:0]};
    assign os9 = {1'b0, r_os[HIGHEST_W-1:0]};

    always_comb begin
        do_rel = (i_func == FUNC_RELEASE)
                 || ((i_func == FUNC_MOVE) && (i_new_slot != i_old_slot));
        do_occ = (i_func == FUNC_OCCUPY)
                 || ((i_func == FUNC_MOVE) && (i_new_slot != i_old_slot));
        os_use = is_usable(i_old_slot, r_highest);
    end

    always_comb begin
        occ_we = 1'b0;  occ_re = 1'b0;  prev_we = 1'b0;
        prev_re = 1'b0; next_we = 1'b0; next_re = 1'b0;
        occ_waddr = idx(r_ns);  occ_raddr = idx(r_ns);
        prev_waddr = idx(r_os); prev_raddr = idx(r_ns);
        next_waddr = idx(r_os); next_raddr = idx(r_ns);
        occ_wdata = '0; prev_wdata = NO_SLOT; next_wdata = NO_SLOT;

        n_highest = i_cfg_we ? i_cfg_wdata : r_highest;
        n_ns = r_ns; n_os = r_os; n_rel_ok = r_rel_ok; n_occ_ok = r_occ_ok;
        n_ns_use = r_ns_use; n_ign = r_ign; n_res_hit = r_res_hit;
        n_hw = r_hw; n_head = r_head; n_tail = r_tail;
        n_before = r_before; n_after = r_after;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_head = r_o_head; n_o_hw = r_o_hw; n_o_users = r_o_users;
        n_o_full = r_o_full; n_o_ign = r_o_ign;

        case (i_op)
            OP_LATCH: begin
                n_ns     = i_new_slot;
                n_os     = i_old_slot;
                n_ns_use = is_usable(i_new_slot, r_highest);
                n_rel_ok = do_rel && os_use;
                n_occ_ok = do_occ && is_usable(i_new_slot, r_highest);
                n_ign    = (do_rel && !os_use && (i_old_slot != NO_SLOT))
                           || (do_occ && !is_usable(i_new_slot, r_highest)
                               && (i_new_slot != NO_SLOT));
            end
            OP_REL_RD: begin
                occ_re    = 1'b1;
                occ_raddr = idx(r_os);
            end
            OP_DEC: begin
                occ_we    = 1'b1;
                occ_waddr = idx(r_os);
                occ_wdata = r_occ_q - CNT_W'(1);
                n_before  = NO_SLOT;
                n_after   = r_head;
            end
            OP_WALK_RD: begin
                next_re    = 1'b1;
                next_raddr = idx(r_after);
                n_before   = r_after;
            end
            OP_WALK_ADV: n_after = r_next_q;
            OP_LINK_A: begin
                prev_we    = 1'b1;
                prev_waddr = idx(r_os);
                prev_wdata = r_before;
                next_we    = 1'b1;
                next_waddr = idx(r_os);
                next_wdata = r_after;
                if (r_before[SLOT_W-1]) begin
                    n_head = os9;
                end
                if (r_after[SLOT_W-1]) begin
                    n_tail = os9;
                end
            end
            OP_LINK_B: begin
                next_we    = !r_before[SLOT_W-1];
                next_waddr = idx(r_before);
                next_wdata = os9;
                prev_we    = !r_after[SLOT_W-1];
                prev_waddr = idx(r_after);
                prev_wdata = os9;
            end
            OP_FILL: begin
                // Skipped slots sit above every listed slot, so they append.
                prev_we    = 1'b1;
                prev_waddr = idx(r_hw);
                prev_wdata = r_tail;
                occ_we     = 1'b1;
                occ_waddr  = idx(r_hw);
                occ_wdata  = '0;
                next_we    = !r_tail[SLOT_W-1];
                next_waddr = idx(r_tail);
                next_wdata = r_hw;
                if (r_tail[SLOT_W-1]) begin
                    n_head = r_hw;
                end
                n_tail = r_hw;
                n_hw   = r_hw + SLOT_W'(1);
            end
            OP_FILL_END: begin
                next_we    = !r_tail[SLOT_W-1];
                next_waddr = idx(r_tail);
                next_wdata = NO_SLOT;
                occ_we     = 1'b1;
                occ_waddr  = idx(r_ns);
                occ_wdata  = CNT_W'(1);
                n_hw       = ns9 + SLOT_W'(1);
            end
            OP_NEW_RD: occ_re = 1'b1;
            OP_LNK_RD: begin
                prev_re = 1'b1;
                next_re = 1'b1;
            end
            OP_UNLINK: begin
                if (r_ns == r_head) begin
                    n_head = r_next_q;
                end
                if (r_ns == r_tail) begin
                    n_tail = r_prev_q;
                end
                next_we    = !r_prev_q[SLOT_W-1];
                next_waddr = idx(r_prev_q);
                next_wdata = r_next_q;
                prev_we    = !r_next_q[SLOT_W-1];
                prev_waddr = idx(r_next_q);
                prev_wdata = r_prev_q;
            end
            OP_INC: begin
                occ_we    = 1'b1;
                occ_wdata = (r_occ_q == CNT_MAX) ? CNT_MAX : r_occ_q + CNT_W'(1);
            end
            OP_RES_RD: begin
                // Slots at or above the high-water mark were never written.
                n_res_hit = r_ns_use && (ns9 < r_hw);
                occ_re    = n_res_hit;
            end
            OP_OUT: begin
                n_out_valid = 1'b1;
                n_o_head    = r_head;
                n_o_hw      = r_hw;
                n_o_users   = r_res_hit ? r_occ_q : '0;
                n_o_full    = (r_hw > {1'b0, r_highest}) && r_head[SLOT_W-1];
                n_o_ign     = r_ign;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (occ_we) begin
            occ_mem[occ_waddr] <= occ_wdata;
        end
        if (occ_re) begin
            r_occ_q <= occ_mem[occ_raddr];
        end
        if (prev_we) begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (prev_re) begin
            r_prev_q <= prev_mem[prev_raddr];
        end
        if (next_we) begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (next_re) begin
            r_next_q <= next_mem[next_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_highest   <= HIGHEST_RST;
            r_hw        <= '0;
            r_head      <= NO_SLOT;
            r_tail      <= NO_SLOT;
            r_out_valid <= 1'b0;
        end else begin
            r_highest   <= n_highest;
            r_hw        <= n_hw;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ns      <= n_ns;
        r_os      <= n_os;
        r_rel_ok  <= n_rel_ok;
        r_occ_ok  <= n_occ_ok;
        r_ns_use  <= n_ns_use;
        r_ign     <= n_ign;
        r_res_hit <= n_res_hit;
        r_before  <= n_before;
        r_after   <= n_after;
        r_o_head  <= n_o_head;
        r_o_hw    <= n_o_hw;
        r_o_users <= n_o_users;
        r_o_full  <= n_o_full;
        r_o_ign   <= n_o_ign;
    end

    always_comb begin
        o_status.rel_go    = r_rel_ok && (os9 < r_hw);
        o_status.occ_ok    = r_occ_ok;
        o_status.new_ge_hw = (ns9 >= r_hw);
        o_status.occ_zero  = (r_occ_q == '0);
        o_status.occ_one   = (r_occ_q == CNT_W'(1));
        o_status.walk_more = !r_after[SLOT_W-1]
                             && (r_after[HIGHEST_W-1:0] < r_os[HIGHEST_W-1:0]);
        o_status.fill_more = (r_hw < ns9);
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_free_head   = r_o_head;
    assign o_next_unused = r_o_hw;
    assign o_slot_users  = r_o_users;
    assign o_table_full  = r_o_full;
    assign o_ignored     = r_o_ign;

endmodule

// ===== rtl/core/sorted_free_slot_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted free-slot allocator
// Occupancy counts, high-water mark and an ascending doubly linked free list.
// ----------------------------------------------------------------------------
// One transaction is taken at a time and gives one result. An occupy that
// passes the high-water mark appends each skipped slot to the free list in
// turn, and a release whose count falls to zero walks the free-list entries
// below the released slot one next-link read at a time for the sorted
// insertion. A result waiting in the output register does not block the
// next transaction from being accepted.
module sorted_free_slot_allocator_core #(
    parameter int MAX_SLOTS = sfsa_pkg::DEF_MAX_SLOTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [sfsa_pkg::FUNC_W-1:0]        i_func,
    input  logic signed [sfsa_pkg::SLOT_W-1:0] i_new_slot,
    input  logic signed [sfsa_pkg::SLOT_W-1:0] i_old_slot,
    input  logic                               i_cfg_we,
    input  logic [sfsa_pkg::HIGHEST_W-1:0]     i_cfg_wdata,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [sfsa_pkg::SLOT_W-1:0] o_free_head,
    output logic [sfsa_pkg::SLOT_W-1:0]        o_next_unused,
    output logic [sfsa_pkg::CNT_W-1:0]         o_slot_users,
    output logic                               o_table_full,
    output logic                               o_ignored
);
    import sfsa_pkg::*;

    t_op     op;
    t_status status;

    sfsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_op       (op)
    );

    sfsa_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (op),
        .o_status      (status),
        .i_func        (i_func),
        .i_new_slot    (i_new_slot),
        .i_old_slot    (i_old_slot),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_free_head   (o_free_head),
        .o_next_unused (o_next_unused),
        .o_slot_users  (o_slot_users),
        .o_table_full  (o_table_full),
        .o_ignored     (o_ignored)
    );

endmodule

// ===== rtl/core/sfsa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted free-slot allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sfsa_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic signed [sfsa_pkg::SLOT_W-1:0] o_free_head,
    input logic [sfsa_pkg::SLOT_W-1:0]        o_next_unused,
    input logic [sfsa_pkg::CNT_W-1:0]         o_slot_users,
    input logic                               o_table_full
);
    import sfsa_pkg::*;

    // One transaction at a time: ready drops once an item is taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a transaction was in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_free_head)
                                           && $stable(o_next_unused)))
        else $error("stalled result changed");

    // The free-list head lies below the high-water mark.
    a_head_below_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_free_head[SLOT_W-1]
                         || ({1'b0, o_free_head[CNT_W-1:0]} < o_next_unused)))
        else $error("free head at or above the high-water mark");

    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_table_full) |-> (o_free_head == NO_SLOT))
        else $error("table full with a free slot listed");

    a_users_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_slot_users != '0)) |-> (o_next_unused != '0))
        else $error("occupied slot reported with nothing used");

endmodule

bind sorted_free_slot_allocator_core sfsa_checker u_sfsa_checker (.*);
